FILE: design/aip_pkg.sv
// Shared types, constants and character codes for the argument integer parser.
package aip_pkg;

    localparam int MAX_CHARS = 1023;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int CH_W      = 8;
    localparam int ARG_W     = 8;
    localparam int VALUE_W   = 64;

    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic [3:0] {
        PH_LINE,
        PH_SKIP,
        PH_GAP,
        PH_START,
        PH_BODY,
        PH_ZERO,
        PH_HEX,
        PH_HEXBAD,
        PH_LETTER,
        PH_OCT,
        PH_DEC,
        PH_STOP,
        PH_END
    } phase_t;

    // One character word as it travels from the input stage to the parser
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } item_t;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2d;
    localparam logic [CH_W-1:0] CH_DIG_0  = 8'h30;
    localparam logic [CH_W-1:0] CH_DIG_7  = 8'h37;
    localparam logic [CH_W-1:0] CH_DIG_9  = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_F   = 8'h46;
    localparam logic [CH_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [CH_W-1:0] CH_UP_Z   = 8'h5a;
    localparam logic [CH_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LOW_F  = 8'h66;
    localparam logic [CH_W-1:0] CH_LOW_X  = 8'h78;
    localparam logic [CH_W-1:0] CH_LOW_Z  = 8'h7a;
    localparam logic [CH_W-1:0] CASE_BIT  = 8'h20;

endpackage

FILE: design/aip_input_stage.sv
// Input register: holds one character word and releases it to the parser.
module aip_input_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  aip_pkg::item_t s_item,
    input  logic          out_free,
    output aip_pkg::item_t item,
    output logic          fire
);
    import aip_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // a last word may only move on when the result register can take it
    assign fire     = valid_reg && (!item_reg.last || out_free);
    assign s_tready = !valid_reg || fire;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: design/aip_parse_core.sv
// Token selection and integer parse state, updated once per character word.
module aip_parse_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  aip_pkg::item_t            item,
    input  logic [aip_pkg::ARG_W-1:0] arg_number,
    output logic                      res_valid,
    output aip_pkg::value_t           res_value
);
    import aip_pkg::*;

    phase_t           phase_reg, phase_next, phase_upd, ph_pre, ph_body;
    logic [ARG_W-1:0] seen_reg, seen_next, seen_upd, seen_inc;
    value_t           acc_reg, acc_next, acc_upd;
    logic             neg_reg, neg_next, neg_upd;
    logic [CH_W-1:0]  letter_reg, letter_next, letter_upd;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_upd;
    logic             ended_reg, ended_next, ended_upd;

    logic [ARG_W-1:0] target;
    logic             ignored, take_char;
    logic [CH_W-1:0]  c;
    logic             is_sep, is_dec, is_oct, is_up, is_low, is_hexl, is_hexu;
    logic [3:0]       digit;

    function automatic value_t current_value(phase_t ph, logic neg, value_t acc,
                                             logic [CH_W-1:0] letter);
        value_t v;
        case (ph)
            PH_HEX, PH_OCT, PH_DEC, PH_STOP: v = neg ? (value_t'(0) - acc) : acc;
            PH_LETTER:                       v = {{(VALUE_W-CH_W){1'b0}}, letter};
            PH_END:                          v = acc;
            default:                         v = '0;
        endcase
        return v;
    endfunction

    assign c        = item.ch;
    assign target   = (arg_number <= ARG_W'(1)) ? '0 : arg_number - ARG_W'(1);
    assign ignored  = ended_reg || (cnt_reg >= CNT_W'(MAX_CHARS));
    assign is_sep   = (c == CH_SPACE) || (c == CH_TAB);
    assign is_dec   = (c >= CH_DIG_0) && (c <= CH_DIG_9);
    assign is_oct   = (c >= CH_DIG_0) && (c <= CH_DIG_7);
    assign is_up    = (c >= CH_UP_A) && (c <= CH_UP_Z);
    assign is_low   = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
    assign is_hexl  = (c >= CH_LOW_A) && (c <= CH_LOW_F);
    assign is_hexu  = (c >= CH_UP_A) && (c <= CH_UP_F);
    // low nibble is the digit for 0-9; a-f and A-F sit nine below their value
    assign digit    = is_dec ? c[3:0] : c[3:0] + 4'd9;
    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + ARG_W'(1);

    // next state
    always_comb
    begin
        phase_upd  = phase_reg;
        seen_upd   = seen_reg;
        acc_upd    = acc_reg;
        neg_upd    = neg_reg;
        letter_upd = letter_reg;
        cnt_upd    = cnt_reg;
        ended_upd  = ended_reg;
        ph_pre     = phase_reg;
        take_char  = 1'b0;

        if (fire && !ignored)
        begin
            cnt_upd = cnt_reg + CNT_W'(1);
            if (c == CH_NUL)
            begin
                ended_upd = 1'b1;
            end
            else
            begin
                if (ph_pre == PH_LINE)
                begin
                    ph_pre = (target == '0) ? PH_START : PH_SKIP;
                end
                case (ph_pre)
                    PH_SKIP:
                    begin
                        phase_upd = is_sep ? PH_GAP : PH_SKIP;
                    end
                    PH_GAP:
                    begin
                        if (!is_sep)
                        begin
                            seen_upd = seen_inc;
                            if (seen_inc != target)
                            begin
                                phase_upd = PH_SKIP;
                            end
                            else
                            begin
                                ph_pre    = PH_START;
                                take_char = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        take_char = 1'b1;
                    end
                endcase
            end
        end

        ph_body = (ph_pre == PH_START) ? PH_BODY : ph_pre;

        if (take_char)
        begin
            phase_upd = ph_pre;
            if (is_sep)
            begin
                // freeze the token's value and ignore the rest of the line
                acc_upd   = current_value(ph_pre, neg_reg, acc_reg, letter_reg);
                neg_upd   = 1'b0;
                phase_upd = PH_END;
            end
            else if (ph_pre == PH_START && c == CH_MINUS)
            begin
                neg_upd   = 1'b1;
                phase_upd = PH_BODY;
            end
            else
            begin
                phase_upd = ph_body;
                case (ph_body)
                    PH_BODY:
                    begin
                        if (c == CH_DIG_0)
                        begin
                            phase_upd = PH_ZERO;
                        end
                        else if (is_up || is_low)
                        begin
                            letter_upd = c | CASE_BIT;
                            phase_upd  = PH_LETTER;
                        end
                        else if (is_dec)
                        begin
                            acc_upd   = {{(VALUE_W-4){1'b0}}, digit};
                            phase_upd = PH_DEC;
                        end
                        else
                        begin
                            acc_upd   = '0;
                            phase_upd = PH_STOP;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (c == CH_LOW_X || c == CH_UP_X)
                        begin
                            acc_upd   = '0;
                            phase_upd = PH_HEX;
                        end
                        else if (is_oct)
                        begin
                            acc_upd   = {{(VALUE_W-4){1'b0}}, digit};
                            phase_upd = PH_OCT;
                        end
                        else
                        begin
                            acc_upd   = '0;
                            phase_upd = PH_STOP;
                        end
                    end
                    PH_HEX:
                    begin
                        if (is_dec || is_hexl || is_hexu)
                        begin
                            acc_upd = {acc_reg[VALUE_W-5:0], digit};
                        end
                        else
                        begin
                            phase_upd = PH_HEXBAD;
                        end
                    end
                    PH_LETTER:
                    begin
                        acc_upd   = '0;
                        phase_upd = PH_STOP;
                    end
                    PH_OCT:
                    begin
                        if (is_oct)
                        begin
                            acc_upd = {acc_reg[VALUE_W-4:0], digit[2:0]};
                        end
                        else
                        begin
                            phase_upd = PH_STOP;
                        end
                    end
                    PH_DEC:
                    begin
                        if (is_dec)
                        begin
                            acc_upd = (acc_reg << 3) + (acc_reg << 1)
                                    + {{(VALUE_W-4){1'b0}}, digit};
                        end
                        else
                        begin
                            phase_upd = PH_STOP;
                        end
                    end
                    default:
                    begin
                        phase_upd = ph_body;
                    end
                endcase
            end
        end

        // clear the line after its last word
        if (fire && item.last)
        begin
            phase_next  = PH_LINE;
            seen_next   = '0;
            acc_next    = '0;
            neg_next    = 1'b0;
            letter_next = '0;
            cnt_next    = '0;
            ended_next  = 1'b0;
        end
        else
        begin
            phase_next  = phase_upd;
            seen_next   = seen_upd;
            acc_next    = acc_upd;
            neg_next    = neg_upd;
            letter_next = letter_upd;
            cnt_next    = cnt_upd;
            ended_next  = ended_upd;
        end
    end

    // outputs
    always_comb
    begin
        res_valid = fire && item.last;
        res_value = current_value(phase_upd, neg_upd, acc_upd, letter_upd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LINE;
            seen_reg   <= '0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            letter_reg <= '0;
            cnt_reg    <= '0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            seen_reg   <= seen_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            letter_reg <= letter_next;
            cnt_reg    <= cnt_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

FILE: design/aip_output_stage.sv
// Result register: holds one parsed value until the downstream side takes it.
module aip_output_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_valid,
    input  aip_pkg::value_t res_value,
    output logic            out_free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output aip_pkg::value_t m_tdata
);
    import aip_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    value_t value_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = value_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            value_reg <= res_value;
        end
    end

endmodule

FILE: design/argument_integer_parser.sv
// Top level of the argument integer parser: config register and stage wiring.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = ch, s_tlast = last
//  m_*       out  m_tvalid/m_tready  m_tdata = value (64-bit two's complement)
//  cfg_*     in   cfg_wr_en          cfg_wr_data = arg_number
//
//  One character word per cycle while nothing stalls: input register, parse
//  logic, result register. A line's value reaches m_tdata at the edge where
//  its last word leaves the input register.
//  Reset (rst_n low, asynchronous) empties both registers, clears the line
//  state and sets arg_number to 1.
//  A stalled result holds the next last word in the input register, and the
//  words behind it wait; other words keep flowing.
module argument_integer_parser
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [aip_pkg::ARG_W-1:0] cfg_wr_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [aip_pkg::CH_W-1:0]  s_tdata,   // [7:0] ch
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output aip_pkg::value_t           m_tdata    // [63:0] value
);
    import aip_pkg::*;

    logic [ARG_W-1:0] arg_reg;
    logic [ARG_W-1:0] arg_next;
    item_t            s_item;
    item_t            item;
    logic             fire;
    logic             out_free;
    logic             res_valid;
    value_t           res_value;

    assign s_item.ch   = s_tdata;
    assign s_item.last = s_tlast;

    always_comb
    begin
        arg_next = arg_reg;
        if (cfg_wr_en)
        begin
            arg_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_reg <= ARG_W'(1);
        end
        else
        begin
            arg_reg <= arg_next;
        end
    end

    aip_input_stage u_input
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .out_free (out_free),
        .item     (item),
        .fire     (fire)
    );

    aip_parse_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item),
        .arg_number (arg_reg),
        .res_valid  (res_valid),
        .res_value  (res_value)
    );

    aip_output_stage u_output
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_value (res_value),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // input side stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> !out_free)
        else $error("input stalled while result register free");

    // a result is never produced into an occupied result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result produced into a full result register");

    // a produced result shows on the output next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> m_tvalid)
        else $error("produced result not presented");

    // a word that is not last never produces a result
    a_last_only: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.last) |-> !res_valid)
        else $error("result without a last word");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the argument integer parser: character stream in, token value out.
module testbench;
    import aip_pkg::*;

    localparam int LIMIT_CYCLES = 25000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_WORDS  = 55;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [ARG_W-1:0]    cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [CH_W-1:0]     s_tdata;   // [7:0] ch
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    value_t              m_tdata;   // [63:0] value

    argument_integer_parser u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Words waiting to go out, and the token values they will produce
    item_t        char_words[$];
    value_t       value_queue[$];
    logic [7:0]   line_buf[$];

    int           send_idle_pct;
    int           recv_stall_pct;
    int           error_count;
    int           words_queued;
    int           words_taken;
    int           lines_sent;
    int           values_checked;
    int           settings_used;
    int           cycle_count;
    bit           word_taken;
    item_t        taken_word;
    value_t       want_value;

    // Parser state as the block should hold it
    phase_t       ph;
    logic [7:0]   tokens_passed;
    value_t       acc;
    logic         neg;
    logic [7:0]   letter_code;
    int           chars_taken;
    logic         line_done;
    logic [7:0]   arg_sel;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit is_sep(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic value_t token_value();
        case (ph)
            PH_HEX, PH_OCT, PH_DEC, PH_STOP: return neg ? (value_t'(0) - acc) : acc;
            PH_LETTER:                       return value_t'(letter_code);
            PH_END:                          return acc;
            default:                         return value_t'(0);
        endcase
    endfunction

    function automatic void clear_line();
        ph            = PH_LINE;
        tokens_passed = 8'd0;
        acc           = '0;
        neg           = 1'b0;
        letter_code   = 8'd0;
        chars_taken   = 0;
        line_done     = 1'b0;
    endfunction

    function automatic void token_char(logic [7:0] c);
        bit dec_d;
        bit oct_d;
        bit alpha;
        dec_d = (c >= CH_DIG_0) && (c <= CH_DIG_9);
        oct_d = (c >= CH_DIG_0) && (c <= CH_DIG_7);
        alpha = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z));
        if (is_sep(c))
        begin
            acc = token_value();
            neg = 1'b0;
            ph  = PH_END;
            return;
        end
        if (ph == PH_START)
        begin
            ph = PH_BODY;
            if (c == CH_MINUS)
            begin
                neg = 1'b1;
                return;
            end
        end
        case (ph)
            PH_BODY:
                if (c == CH_DIG_0)
                    ph = PH_ZERO;
                else if (alpha)
                begin
                    letter_code = c | CASE_BIT;
                    ph          = PH_LETTER;
                end
                else if (dec_d)
                begin
                    acc = value_t'(c - CH_DIG_0);
                    ph  = PH_DEC;
                end
                else
                begin
                    acc = '0;
                    ph  = PH_STOP;
                end
            PH_ZERO:
                if ((c == CH_LOW_X) || (c == CH_UP_X))
                begin
                    acc = '0;
                    ph  = PH_HEX;
                end
                else if (oct_d)
                begin
                    acc = value_t'(c - CH_DIG_0);
                    ph  = PH_OCT;
                end
                else
                begin
                    acc = '0;
                    ph  = PH_STOP;
                end
            PH_HEX:
                if (dec_d)
                    acc = acc * 16 + value_t'(c - CH_DIG_0);
                else if ((c >= CH_LOW_A) && (c <= CH_LOW_F))
                    acc = acc * 16 + value_t'(c - CH_LOW_A) + 10;
                else if ((c >= CH_UP_A) && (c <= CH_UP_F))
                    acc = acc * 16 + value_t'(c - CH_UP_A) + 10;
                else
                    ph = PH_HEXBAD;
            PH_LETTER:
            begin
                acc = '0;
                ph  = PH_STOP;
            end
            PH_OCT:
                if (oct_d)
                    acc = acc * 8 + value_t'(c - CH_DIG_0);
                else
                    ph = PH_STOP;
            PH_DEC:
                if (dec_d)
                    acc = acc * 10 + value_t'(c - CH_DIG_0);
                else
                    ph = PH_STOP;
            default: ;
        endcase
    endfunction

    function automatic void feed_char(logic [7:0] c);
        logic [7:0] target;
        target = (arg_sel <= 8'd1) ? 8'd0 : arg_sel - 8'd1;
        // Drop everything after a NUL or past the buffer limit
        if (line_done || (chars_taken >= MAX_CHARS))
            return;
        chars_taken++;
        if (c == CH_NUL)
        begin
            line_done = 1'b1;
            return;
        end
        if (ph == PH_LINE)
            ph = (target == 8'd0) ? PH_START : PH_SKIP;
        if (ph == PH_SKIP)
        begin
            if (is_sep(c))
                ph = PH_GAP;
            return;
        end
        if (ph == PH_GAP)
        begin
            if (is_sep(c))
                return;
            if (tokens_passed < 8'd255)
                tokens_passed++;
            if (tokens_passed != target)
            begin
                ph = PH_SKIP;
                return;
            end
            ph = PH_START;
        end
        token_char(c);
    endfunction

    // Sample both handshakes at the rising edge; predict on every accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                taken_word = char_words.pop_front();
                word_taken = 1'b1;
                words_taken++;
                feed_char(taken_word.ch);
                if (taken_word.last)
                begin
                    value_queue.push_back(token_value());
                    clear_line();
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (value_queue.size() == 0)
                begin
                    $display("%0t: unexpected result word: expected none, actual %0d",
                             $time, $signed(m_tdata));
                    error_count++;
                end
                else
                begin
                    want_value = value_queue.pop_front();
                    values_checked++;
                    if (m_tdata !== want_value)
                    begin
                        $display("%0t: value mismatch: expected %0d (0x%h), actual %0d (0x%h)",
                                 $time, $signed(want_value), want_value,
                                 $signed(m_tdata), m_tdata);
                        error_count++;
                    end
                end
            end
        end
    end

    // Drive at the falling edge; hold a word until it has been taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || word_taken)
            begin
                if ((char_words.size() > 0) && ($urandom_range(99) >= send_idle_pct))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= char_words[0].ch;
                    s_tlast  <= char_words[0].last;
                end
                else
                    s_tvalid <= 1'b0;
            end
            word_taken = 1'b0;
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d values still due",
                     cycle_count, value_queue.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_word(logic [7:0] c, logic last);
        item_t w;
        w.ch   = c;
        w.last = last;
        char_words.push_back(w);
        words_queued++;
        if (last)
            lines_sent++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_word(s[i], i == s.len() - 1);
    endtask

    task automatic emit_line();
        if (line_buf.size() == 0)
            line_buf.push_back(8'($urandom_range(1, 255)));
        for (int i = 0; i < line_buf.size(); i++)
            push_word(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic add_sep();
        line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic add_digit();
        line_buf.push_back(CH_DIG_0 + 8'($urandom_range(9)));
    endtask

    task automatic add_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_sep(c));
        line_buf.push_back(c);
    endtask

    task automatic add_token();
        int         n;
        logic [7:0] d;
        case ($urandom_range(9))
            0, 1:
            begin
                if ($urandom_range(2) == 0)
                    line_buf.push_back(CH_MINUS);
                n = ($urandom_range(3) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 6);
                repeat (n) add_digit();
                if ($urandom_range(3) == 0)
                    add_plain();
            end
            2:
            begin
                line_buf.push_back(CH_DIG_0);
                n = $urandom_range(0, 22);
                repeat (n)
                begin
                    if ($urandom_range(4) == 0)
                        add_digit();
                    else
                        line_buf.push_back(CH_DIG_0 + 8'($urandom_range(7)));
                end
            end
            3, 4:
            begin
                if ($urandom_range(3) == 0)
                    line_buf.push_back(CH_MINUS);
                line_buf.push_back(CH_DIG_0);
                line_buf.push_back($urandom_range(1) ? CH_LOW_X : CH_UP_X);
                n = $urandom_range(0, 17);
                for (int i = 0; i < n; i++)
                begin
                    d = 8'($urandom_range(15));
                    if ((i == n / 2) && ($urandom_range(4) == 0))
                        add_plain();
                    else if (d < 10)
                        line_buf.push_back(CH_DIG_0 + d);
                    else
                        line_buf.push_back(($urandom_range(1) ? CH_LOW_A : CH_UP_A) + d - 8'd10);
                end
            end
            5:
            begin
                if ($urandom_range(2) == 0)
                    line_buf.push_back(CH_MINUS);
                line_buf.push_back(($urandom_range(1) ? CH_LOW_A : CH_UP_A)
                                   + 8'($urandom_range(25)));
                if ($urandom_range(2) == 0)
                    add_plain();
            end
            6:
            begin
                n = $urandom_range(1, 3);
                repeat (n) add_plain();
            end
            7:
            begin
                line_buf.push_back(CH_MINUS);
                if ($urandom_range(1))
                    add_plain();
            end
            8:
            begin
                if ($urandom_range(1))
                    line_buf.push_back(CH_MINUS);
                n = $urandom_range(1, 3);
                repeat (n) line_buf.push_back(CH_DIG_0);
            end
            default:
            begin
                n = $urandom_range(1, 4);
                repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic gen_line();
        int ntok;
        if ($urandom_range(9) == 0)
        begin
            // noise line of raw bytes
            ntok = $urandom_range(1, 8);
            repeat (ntok) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(5) == 0)
                add_sep();
            ntok = $urandom_range(1, 5);
            for (int t = 0; t < ntok; t++)
            begin
                add_token();
                if (t != ntok - 1)
                begin
                    add_sep();
                    if ($urandom_range(3) == 0)
                        add_sep();
                end
            end
            if ($urandom_range(5) == 0)
                add_sep();
            if ($urandom_range(7) == 0)
            begin
                line_buf.push_back(CH_NUL);
                ntok = $urandom_range(0, 3);
                repeat (ntok) line_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        emit_line();
    endtask

    task automatic wait_results();
        while ((char_words.size() != 0) || (value_queue.size() != 0))
            @(posedge clk);
    endtask

    task automatic drain();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_arg(logic [7:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        arg_sel      = v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
            3:       begin send_idle_pct = 14; recv_stall_pct = 14; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    initial
    begin
        logic [7:0] arg_v;
        int         phase_start;
        bit         paused;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        word_taken     = 1'b0;
        error_count    = 0;
        words_queued   = 0;
        words_taken    = 0;
        lines_sent     = 0;
        values_checked = 0;
        settings_used  = 1;
        cycle_count    = 0;
        paused         = 1'b0;
        arg_sel        = 8'd1;
        clear_line();
        set_idling(0);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lines with the reset selection (first token)
        push_text("0");
        push_text("9");
        push_text("-9223372036854775808");
        push_text("18446744073709551615");
        push_text("99999999999999999999");
        push_text("0x");
        push_text("0xFFFFFFFFFFFFFFFF");
        push_text("-0x1aF");
        push_text("0x12g4");
        push_text("0777");
        push_text("0789");
        push_text("-017");
        push_text("Q");
        push_text("-q");
        push_text("qz");
        push_text("12ab");
        push_text("-");
        push_text(" 5");
        push_text("\t-3");
        push_text("55 ");
        // non-ASCII codes are plain characters
        push_word(8'hff, 1'b0);
        push_word(CH_DIG_7, 1'b1);
        push_word(CH_DIG_9, 1'b0);
        push_word(8'h80, 1'b1);
        // NUL ends the string, last lands on an ignored word
        push_word(CH_DIG_7, 1'b0);
        push_word(CH_NUL, 1'b0);
        push_word(CH_SPACE, 1'b0);
        push_word(CH_DIG_9, 1'b1);
        drain();

        for (int p = 1; p <= 8; p++)
        begin
            case (p)
                1:       arg_v = 8'd0;
                2:       arg_v = 8'd2;
                3:       arg_v = 8'd3;
                4:       arg_v = 8'd255;
                5:       arg_v = 8'd1;
                6:       arg_v = 8'd4;
                7:       arg_v = 8'($urandom_range(2, 6));
                default: arg_v = 8'($urandom_range(0, 255));
            endcase
            write_arg(arg_v);
            set_idling(p % 4);
            phase_start = words_queued;
            while (words_queued - phase_start < PHASE_WORDS)
            begin
                gen_line();
                if ((p == 3) && !paused && (words_queued - phase_start >= PHASE_WORDS / 2))
                begin
                    // hold the sender until every due value is out
                    wait_results();
                    paused = 1'b1;
                end
            end
            drain();
        end

        $display("Sent %0d character words in %0d lines; checked %0d values", words_taken,
                 lines_sent, values_checked);
        $display("over %0d token selections with four idling patterns on both sides",
                 settings_used);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
design/aip_pkg.sv
design/aip_input_stage.sv
design/aip_parse_core.sv
design/aip_output_stage.sv
design/argument_integer_parser.sv
tb/testbench.sv
